// ===== hdl/rdf_pkg.sv =====
// Package for the recent ID duplicate filter: store geometry, the controller
// state type and the request bundle that the controller sends to the ID store.
// No dependencies.
`default_nettype none

package rdf_pkg;

   // The depth must be a power of two so that slot arithmetic wraps naturally.
   localparam int STORE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int OCC_W       = ADDR_W + 1;
   localparam int ID_W        = 16;
   localparam int LIMIT_W     = 11;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000);

   typedef enum logic [1:0] {
      RDF_IDLE,
      RDF_SEARCH,
      RDF_FINISH
   } rdf_state_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [ID_W-1:0]   wr_data;
   } mem_req_type;

endpackage

`default_nettype wire

// ===== hdl/rdf_id_store.sv =====
// Single-port-read, single-port-write memory holding the remembered IDs.
// Depends on rdf_pkg for its geometry and the request bundle.
`default_nettype none

module rdf_id_store (
   input  wire logic                    clock,
   input  wire rdf_pkg::mem_req_type    mem_req,
   output logic [rdf_pkg::ID_W-1:0]     rd_data_ff
);

   logic [rdf_pkg::ID_W-1:0] mem [rdf_pkg::STORE_DEPTH];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/recent_id_duplicate_filter_core.sv =====
// Top level of the recent ID duplicate filter: search controller, window
// registers and response register. Depends on rdf_pkg and rdf_id_store.
//
// Each request ID is compared against every ID in the current window, read
// one entry per cycle from the single read port of the ID memory. The finish
// step waits for as long as an earlier response is stalled on rsp_stall. The
// filter works on one request at a time; a new request may be taken while the
// previous response still waits on rsp_stall. A non-duplicate ID is appended
// at the young end of the window, and the oldest entry is dropped once the
// occupancy would reach window_limit or the store depth, so at most the
// smaller of window_limit-1 and STORE_DEPTH-1 IDs are remembered, unless the
// limit was lowered below the occupancy. The memory needs no clearing after
// reset: only entries inside the occupancy are ever compared.
`default_nettype none

module recent_id_duplicate_filter_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [rdf_pkg::ID_W-1:0]       req_request_id,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_is_duplicate,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [rdf_pkg::LIMIT_W-1:0]    csr_window_limit
);

   rdf_pkg::rdf_state_type           state_ff, state_in;
   logic [rdf_pkg::OCC_W-1:0]        occ_ff, occ_in;
   logic [rdf_pkg::ADDR_W-1:0]       oldest_ff, oldest_in;
   logic [rdf_pkg::LIMIT_W-1:0]      limit_ff;
   logic [rdf_pkg::ID_W-1:0]         id_ff, id_in;
   logic [rdf_pkg::OCC_W-1:0]        cnt_ff, cnt_in;
   logic                             rd_pend_ff, rd_pend_in;
   logic                             hit_ff, hit_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_dup_ff, rsp_dup_in;
   logic [rdf_pkg::OCC_W-1:0]        occ_inc;
   logic                             out_free;
   rdf_pkg::mem_req_type             mem_req;
   logic [rdf_pkg::ID_W-1:0]         rd_data;

   rdf_id_store u_id_store (
      .clock      (clock),
      .mem_req    (mem_req),
      .rd_data_ff (rd_data)
   );

   assign req_stall        = (state_ff != rdf_pkg::RDF_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_duplicate = rsp_dup_ff;
   assign out_free         = !rsp_valid_ff || !rsp_stall;
   assign occ_inc          = occ_ff + rdf_pkg::OCC_W'(1);

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      oldest_in    = oldest_ff;
      id_in        = id_ff;
      cnt_in       = cnt_ff;
      rd_pend_in   = 1'b0;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_dup_in   = rsp_dup_ff;
      mem_req      = '0;
      mem_req.rd_addr = oldest_ff + cnt_ff[rdf_pkg::ADDR_W-1:0];
      mem_req.wr_addr = oldest_ff + occ_ff[rdf_pkg::ADDR_W-1:0];
      mem_req.wr_data = id_ff;

      unique case (state_ff)
         rdf_pkg::RDF_IDLE: begin
            if (req_valid) begin
               id_in    = req_request_id;
               cnt_in   = '0;
               hit_in   = 1'b0;
               state_in = rdf_pkg::RDF_SEARCH;
            end
         end
         rdf_pkg::RDF_SEARCH: begin
            // Reads are issued in window order; each result is compared in the next
            // cycle, after the memory output register.
            if (cnt_ff != occ_ff) begin
               mem_req.rd_en = 1'b1;
               rd_pend_in    = 1'b1;
               cnt_in        = cnt_ff + rdf_pkg::OCC_W'(1);
            end else if (!rd_pend_ff) begin
               state_in = rdf_pkg::RDF_FINISH;
            end
            if (rd_pend_ff && (rd_data == id_ff)) begin
               hit_in = 1'b1;
            end
         end
         rdf_pkg::RDF_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dup_in   = hit_ff;
               state_in     = rdf_pkg::RDF_IDLE;
               if (!hit_ff) begin
                  mem_req.wr_en = 1'b1;
                  if ((occ_inc >= rdf_pkg::OCC_W'(limit_ff)) ||
                      (occ_inc >= rdf_pkg::OCC_W'(rdf_pkg::STORE_DEPTH))) begin
                     // The push and the eviction cancel out in the count.
                     oldest_in = oldest_ff + rdf_pkg::ADDR_W'(1);
                  end else begin
                     occ_in = occ_inc;
                  end
               end
            end
         end
         default: begin
            state_in = rdf_pkg::RDF_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rdf_pkg::RDF_IDLE;
         occ_ff       <= '0;
         oldest_ff    <= '0;
         limit_ff     <= rdf_pkg::LIMIT_RESET;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         oldest_ff    <= oldest_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_window_limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      id_ff      <= id_in;
      cnt_ff     <= cnt_in;
      hit_ff     <= hit_in;
      rsp_dup_ff <= rsp_dup_in;
   end

endmodule

`default_nettype wire

// ===== hdl/rdf_checker.sv =====
// Port-level checker for recent_id_duplicate_filter_core, with its bind.
// Depends only on the ports of the top level.
`default_nettype none

module rdf_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_stall,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic                           rsp_is_duplicate
);

   logic [1:0] outstanding_ff;
   logic       req_acc;
   logic       rsp_acc;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   // Transactions accepted whose response has not yet been taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_ff + {1'b0, req_acc} - {1'b0, rsp_acc};
      end
   end

   // A stalled response keeps its flag and its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_is_duplicate))
      else $error("response changed while stalled");

   // Only one request is searched at a time.
   a_one_in_search: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> req_stall)
      else $error("request accepted while a search is in progress");

   // No response without a matching request.
   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 2'd0)
      else $error("response without an outstanding request");

   // At most one request searching plus one response waiting.
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff != 2'd3)
      else $error("too many transactions outstanding");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind recent_id_duplicate_filter_core rdf_checker u_rdf_checker (.*);

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for recent_id_duplicate_filter_core. It mirrors the ID window
// and predicts the drop or forward verdict for every request transaction.
// Depends on rdf_pkg and the RTL of the filter.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD  = 10;
   localparam int CYCLE_LIMIT   = 6_000_000;
   localparam int MAX_LATENCY   = rdf_pkg::STORE_DEPTH + 6;
   localparam int MAX_GAP       = 16;
   localparam int VERDICT_SLOTS = 8;
   localparam int RECENT_SLOTS  = 64;

   typedef struct packed {
      logic [rdf_pkg::ID_W-1:0] request_id;
      logic                     is_duplicate;
   } verdict_type;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [rdf_pkg::ID_W-1:0]    req_request_id;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic                        rsp_is_duplicate;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [rdf_pkg::LIMIT_W-1:0] csr_window_limit;

   // Mirror of the filter state.
   logic [rdf_pkg::ID_W-1:0]    seen_ids [rdf_pkg::STORE_DEPTH];
   int unsigned                 window_head;
   int unsigned                 window_fill;
   logic [rdf_pkg::LIMIT_W-1:0] limit_model;

   // Expected verdicts in acceptance order, held in a small ring.
   verdict_type                 verdict_buf [VERDICT_SLOTS];
   int                          verdict_wr;
   int                          verdict_rd;
   int                          verdict_cnt;
   logic [rdf_pkg::ID_W-1:0]    recent_ids [RECENT_SLOTS];
   int                          recent_wr;
   int                          recent_cnt;
   int                          error_count;
   int                          cycle_count;
   int                          hold_len;
   bit                          idle_gaps;

   recent_id_duplicate_filter_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_request_id   (req_request_id),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_is_duplicate (rsp_is_duplicate),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_window_limit (csr_window_limit)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   function automatic int draw_gap();
      return idle_gaps ? int'($urandom_range(MAX_GAP, 0)) : 0;
   endfunction

   function automatic void verdict_put(input verdict_type v);
      verdict_buf[verdict_wr] = v;
      verdict_wr = (verdict_wr + 1) % VERDICT_SLOTS;
      verdict_cnt++;
   endfunction

   function automatic verdict_type verdict_take();
      verdict_type v;
      v = verdict_buf[verdict_rd];
      verdict_rd = (verdict_rd + 1) % VERDICT_SLOTS;
      verdict_cnt--;
      return v;
   endfunction

   // Keeps the last RECENT_SLOTS request IDs for picking repeats.
   function automatic void remember_id(input logic [rdf_pkg::ID_W-1:0] id);
      recent_ids[recent_wr] = id;
      recent_wr = (recent_wr + 1) % RECENT_SLOTS;
      if (recent_cnt < RECENT_SLOTS) recent_cnt++;
   endfunction

   // Searches the mirrored window and updates it exactly as the filter does.
   function automatic logic filter_request(input logic [rdf_pkg::ID_W-1:0] id);
      int unsigned slot;
      logic        hit;
      slot = window_head;
      hit  = 1'b0;
      for (int k = 0; k < window_fill; k++) begin
         if (seen_ids[slot] == id) hit = 1'b1;
         slot = (slot + 1) % rdf_pkg::STORE_DEPTH;
      end
      if (!hit) begin
         seen_ids[slot] = id;
         window_fill++;
         if (window_fill >= limit_model || window_fill >= rdf_pkg::STORE_DEPTH) begin
            window_head = (window_head + 1) % rdf_pkg::STORE_DEPTH;
            window_fill--;
         end
      end
      return hit;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(input logic [rdf_pkg::ID_W-1:0] id);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_request_id <= id;
      do @(posedge clock); while (req_stall);
      verdict_put({id, filter_request(id)});
      remember_id(id);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (verdict_cnt != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_window_limit(input logic [rdf_pkg::LIMIT_W-1:0] value);
      csr_valid        <= 1'b1;
      csr_window_limit <= value;
      do @(posedge clock); while (!csr_ready);
      limit_model = value;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Receiver: a random hold-off before each result, or a long one on request.
   always begin : rsp_driver
      int wait_n;
      @(negedge clock);
      if (hold_len != 0) begin
         wait_n   = hold_len;
         hold_len = 0;
      end else begin
         wait_n = draw_gap();
      end
      if (wait_n > 0) begin
         rsp_stall <= 1'b1;
         repeat (wait_n) @(negedge clock);
      end
      rsp_stall <= 1'b0;
      do @(posedge clock); while (!(rsp_valid && !rsp_stall));
   end

   always @(posedge clock) begin : rsp_checker
      verdict_type expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_cnt == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected response transaction: is_duplicate=%0b", rsp_is_duplicate);
         end else begin
            expected = verdict_take();
            if (rsp_is_duplicate !== expected.is_duplicate) begin
               error_count++;
               if (error_count <= 10)
                  $display("id %h: is_duplicate expected %0b, got %0b", expected.request_id,
                           expected.is_duplicate, rsp_is_duplicate);
            end
         end
      end
   end

   // Limit 0 or 1 evicts each new ID at once, so nothing repeats; 2 keeps one ID.
   task automatic test_tiny_limits();
      write_window_limit(rdf_pkg::LIMIT_W'(1));
      send_request(16'h0000);
      send_request(16'h0000);
      send_request(16'hFFFF);
      send_request(16'hFFFF);
      wait_idle();
      write_window_limit(rdf_pkg::LIMIT_W'(0));
      send_request(16'h5A5A);
      send_request(16'h5A5A);
      wait_idle();
      write_window_limit(rdf_pkg::LIMIT_W'(2));
      send_request(16'hA5A5);
      send_request(16'hA5A5);
      send_request(16'h0001);
      send_request(16'hA5A5);
      send_request(16'h0001);
      wait_idle();
   endtask

   // Lowering the limit below the occupancy keeps the window at its current size.
   task automatic test_limit_lowered();
      write_window_limit(rdf_pkg::LIMIT_W'(8));
      for (int i = 0; i < 6; i++) send_request(rdf_pkg::ID_W'(16'h1000 + i));
      wait_idle();
      write_window_limit(rdf_pkg::LIMIT_W'(3));
      send_request(16'h2000);
      send_request(16'h1000);
      send_request(16'h1005);
      send_request(16'h2000);
      send_request(16'h1002);
      wait_idle();
   endtask

   // The receiver holds off for a long stretch so that the filter must stall its input.
   task automatic test_back_pressure();
      idle_gaps = 1'b0;
      hold_len  = 3000;
      for (int i = 0; i < 24; i++) send_request(rdf_pkg::ID_W'($urandom_range(15, 0)));
      wait_idle();
   endtask

   task automatic test_random_traffic();
      logic [rdf_pkg::ID_W-1:0] id;
      int                       pick;
      for (int phase = 0; phase < 10; phase++) begin
         case ($urandom_range(9, 0))
            0:       write_window_limit(rdf_pkg::LIMIT_W'($urandom_range(1, 0)));
            1:       write_window_limit(rdf_pkg::LIMIT_W'(2));
            2:       write_window_limit(rdf_pkg::LIMIT_W'(2047));
            3:       write_window_limit(rdf_pkg::LIMIT_RESET);
            default: write_window_limit(rdf_pkg::LIMIT_W'($urandom_range(64, 3)));
         endcase
         idle_gaps = ($urandom_range(3, 0) != 0);
         for (int n = 0; n < 58; n++) begin
            pick = $urandom_range(9, 0);
            // Mostly IDs seen lately, so that duplicates and evictions both occur.
            if (pick < 6 && recent_cnt != 0)
               id = recent_ids[$urandom_range(recent_cnt - 1, 0)];
            else if (pick < 8)
               id = rdf_pkg::ID_W'($urandom_range(31, 0));
            else
               id = rdf_pkg::ID_W'($urandom_range(65535, 0));
            send_request(id);
         end
         wait_idle();
      end
   endtask

   // A limit above the store depth lets the window fill until the store itself evicts.
   task automatic test_store_saturation();
      idle_gaps = 1'b0;
      write_window_limit(rdf_pkg::LIMIT_W'(2047));
      for (int i = 0; i < rdf_pkg::STORE_DEPTH + 16; i++)
         send_request(rdf_pkg::ID_W'(16'hB000 + i));
      idle_gaps = 1'b1;
      send_request(16'hB000);
      send_request(rdf_pkg::ID_W'(16'hB000 + rdf_pkg::STORE_DEPTH + 15));
      send_request(16'hB011);
      send_request(16'hB010);
      wait_idle();
      write_window_limit(rdf_pkg::LIMIT_W'(rdf_pkg::STORE_DEPTH));
      send_request(16'hC000);
      send_request(16'hC000);
      send_request(16'hB012);
      wait_idle();
      write_window_limit(rdf_pkg::LIMIT_W'(rdf_pkg::STORE_DEPTH + 1));
      send_request(16'hC001);
      send_request(16'hC000);
      send_request(16'hB013);
      wait_idle();
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_request_id   = '0;
      csr_valid        = 1'b0;
      csr_window_limit = '0;
      window_head      = 0;
      window_fill      = 0;
      limit_model      = rdf_pkg::LIMIT_RESET;
      verdict_wr       = 0;
      verdict_rd       = 0;
      verdict_cnt      = 0;
      recent_wr        = 0;
      recent_cnt       = 0;
      error_count      = 0;
      cycle_count      = 0;
      hold_len         = 0;
      idle_gaps        = 1'b1;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_tiny_limits();
      test_limit_lowered();
      test_random_traffic();
      test_back_pressure();
      test_store_saturation();

      wait_idle();
      repeat (MAX_LATENCY) @(posedge clock);
      if (verdict_cnt != 0) begin
         error_count += verdict_cnt;
         $display("%0d response transactions never arrived", verdict_cnt);
      end
      if (error_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/rdf_pkg.sv
hdl/rdf_id_store.sv
hdl/recent_id_duplicate_filter_core.sv
hdl/rdf_checker.sv
test/tb_top.sv
